// File: rtl/gconv_pkg.sv
// ----------------------------------------------------------------------------
// gconv_pkg
// Shared types and constants of the streaming 3x3 grayscale convolution.
// ----------------------------------------------------------------------------
package gconv_pkg;

    localparam int PIX_W  = 8;
    localparam int TAPS   = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_TOP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_MID     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_BOT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd4;

    typedef logic [PIX_W-1:0] t_pixel;

    typedef struct packed {
        t_pixel row_bot;
        t_pixel row_mid;
        t_pixel row_top;
    } t_column;

    typedef struct packed {
        logic            shift;
        logic            capture;
        logic [TAPS-1:0] row_ok;
        logic            col_ok;
    } t_cell_ctl;

endpackage

// File: rtl/gconv_line_buf.sv
// ----------------------------------------------------------------------------
// gconv_line_buf
// Two line buffers held as one memory of pixel pairs, with a clearing sweep
// after reset.
// ----------------------------------------------------------------------------
module gconv_line_buf #(
    parameter int DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]      i_rd_addr,
    output logic [2*gconv_pkg::PIX_W-1:0] o_rd_data,
    input  logic                          i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]      i_wr_addr,
    input  logic [2*gconv_pkg::PIX_W-1:0] i_wr_data,
    output logic                          o_busy
);

    localparam int AW = $clog2(DEPTH);

    logic [2*gconv_pkg::PIX_W-1:0] r_mem [DEPTH];
    logic [2*gconv_pkg::PIX_W-1:0] r_rd_data;
    logic                          r_busy;
    logic [AW-1:0]                 r_clr_addr;
    logic                          clr_last;

    assign clr_last  = (r_clr_addr == AW'(DEPTH - 1));
    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_busy     <= !clr_last;
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// File: rtl/gconv_cell.sv
// ----------------------------------------------------------------------------
// gconv_cell
// One window column: holds three pixels, hands them to its left neighbor on
// each shift, and forms the three masked tap products of its column.
// ----------------------------------------------------------------------------
module gconv_cell #(
    parameter int COEF_BITS = 16
) (
    input  logic                                      i_clk,
    input  gconv_pkg::t_cell_ctl                      i_ctl,
    input  gconv_pkg::t_column                        i_column,
    output gconv_pkg::t_column                        o_column,
    input  logic signed [COEF_BITS-1:0]               i_coef [gconv_pkg::TAPS],
    output logic signed [COEF_BITS+gconv_pkg::PIX_W:0] o_prod [gconv_pkg::TAPS]
);

    localparam int PW = COEF_BITS + gconv_pkg::PIX_W + 1;

    gconv_pkg::t_column    r_col;
    gconv_pkg::t_pixel     pix    [gconv_pkg::TAPS];
    logic signed [PW-1:0]  n_prod [gconv_pkg::TAPS];
    logic signed [PW-1:0]  r_prod [gconv_pkg::TAPS];

    assign pix[0]   = r_col.row_top;
    assign pix[1]   = r_col.row_mid;
    assign pix[2]   = r_col.row_bot;
    assign o_column = r_col;

    always_comb begin
        for (int k = 0; k < gconv_pkg::TAPS; k++) begin
            if (i_ctl.row_ok[k] && i_ctl.col_ok) begin
                n_prod[k] = PW'($signed({1'b0, pix[k]})) * PW'(i_coef[k]);
            end else begin
                n_prod[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_col <= i_column;
        end
        if (i_ctl.capture) begin
            for (int k = 0; k < gconv_pkg::TAPS; k++) begin
                r_prod[k] <= n_prod[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < gconv_pkg::TAPS; k++) begin
            o_prod[k] = r_prod[k];
        end
    end

endmodule

// File: rtl/grayscale_conv2d_clamp.sv
// ----------------------------------------------------------------------------
// grayscale_conv2d_clamp
// Streaming 3x3 zero-padded convolution of 8-bit grayscale pixels.
// Throughput is one item per cycle while not stalled; the line buffer memory takes
// one item per cycle. A result passes stage 1, the window cells, the products and
// the sum to the output register; the item that completes its window is frame_width+1
// items after its centre pixel. After reset the line buffer is cleared, during which
// no item is taken; configuration registers return to their defaults at once.
// ----------------------------------------------------------------------------
module grayscale_conv2d_clamp #(
    parameter int KERNEL_SIZE = 3,
    parameter int MAX_WIDTH   = 1024,
    parameter int COEF_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_pixel_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_pixel_out,
    output logic        o_row_end,
    output logic        o_frame_end,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = CW + 1;
    localparam int PW   = COEF_BITS + gconv_pkg::PIX_W + 1;
    localparam int SW   = PW + 4;
    localparam int TAPS = gconv_pkg::TAPS;
    localparam int PXW  = gconv_pkg::PIX_W;

    logic [47:0] r_coef_top;
    logic [47:0] r_coef_mid;
    logic [47:0] r_coef_bot;
    logic [10:0] r_frame_width;
    logic [15:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_top     <= 48'h0000_0000_0000;
            r_coef_mid     <= 48'h0000_0100_0000;
            r_coef_bot     <= 48'h0000_0000_0000;
            r_frame_width  <= 11'd1024;
            r_frame_height <= 16'd768;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gconv_pkg::CFG_COEF_TOP:     r_coef_top     <= i_cfg_data;
                gconv_pkg::CFG_COEF_MID:     r_coef_mid     <= i_cfg_data;
                gconv_pkg::CFG_COEF_BOT:     r_coef_bot     <= i_cfg_data;
                gconv_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[10:0];
                gconv_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Effective geometry.
    logic [12:0]   fw_ext;
    logic [WW-1:0] w_eff;
    logic [15:0]   h_eff;

    always_comb begin
        fw_ext = 13'(r_frame_width);
        if (r_frame_width == '0) begin
            w_eff = WW'(1);
        end else if (fw_ext > 13'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(fw_ext);
        end
        h_eff = (r_frame_height == '0) ? 16'd1 : r_frame_height;
    end

    // Kernel coefficients.
    logic [47:0]                 coef_row [TAPS];
    logic signed [COEF_BITS-1:0] coef     [TAPS][TAPS];

    assign coef_row[0] = r_coef_top;
    assign coef_row[1] = r_coef_mid;
    assign coef_row[2] = r_coef_bot;

    always_comb begin
        for (int r = 0; r < TAPS; r++) begin
            for (int c = 0; c < TAPS; c++) begin
                if (KERNEL_SIZE <= 1) begin
                    coef[r][c] = (r == 1 && c == 1) ? r_coef_top[COEF_BITS-1:0] : '0;
                end else if (KERNEL_SIZE == 2 && (r == 2 || c == 2)) begin
                    coef[r][c] = '0;
                end else begin
                    coef[r][c] = coef_row[r][16*c +: COEF_BITS];
                end
            end
        end
    end

    // Pipeline handshake.
    logic line_busy;
    logic acc;
    logic ld2, ld3, ld4, ld_out;
    logic adv1, adv2, adv3, adv4;
    logic mv23;

    logic r_v1, r_v2, r_v3, r_v4, r_o_valid;
    logic r_emit1, r_emit2;

    assign ld_out  = !r_o_valid || i_ready;
    assign adv4    = r_v4 && ld_out;
    assign ld4     = !r_v4 || adv4;
    assign adv3    = r_v3 && ld4;
    assign ld3     = !r_v3 || adv3;
    assign adv2    = r_v2 && (!r_emit2 || ld3);
    assign mv23    = adv2 && r_emit2;
    assign ld2     = !r_v2 || adv2;
    assign adv1    = r_v1 && ld2;
    assign o_ready = !line_busy && (!r_v1 || adv1);
    assign acc     = i_valid && o_ready;

    // Position counters, advanced as each item is accepted.
    logic [CW-1:0] r_in_col;
    logic [1:0]    r_in_row;
    logic [CW-1:0] r_out_col;
    logic [15:0]   r_out_row;

    logic          emit;
    logic          in_col_last;
    logic          rend;
    logic          fend;
    logic [2:0]    row_ok;
    logic [2:0]    col_ok;
    logic [CW-1:0] n_in_col;
    logic [1:0]    n_in_row;
    logic [CW-1:0] n_out_col;
    logic [15:0]   n_out_row;
    gconv_pkg::t_pixel px;

    always_comb begin
        px          = i_kind ? '0 : i_pixel_in;
        emit        = (r_in_row == 2'd2) || (r_in_row == 2'd1 && r_in_col != '0);
        in_col_last = (WW'(r_in_col) + WW'(1)) >= w_eff;
        rend        = (WW'(r_out_col) + WW'(1)) >= w_eff;
        fend        = rend && ((17'(r_out_row) + 17'd1) >= 17'(h_eff));
        row_ok[0]   = (r_out_row != '0);
        row_ok[1]   = (r_out_row < h_eff);
        row_ok[2]   = (17'(r_out_row) + 17'd1) < 17'(h_eff);
        col_ok[0]   = (r_out_col != '0);
        col_ok[1]   = WW'(r_out_col) < w_eff;
        col_ok[2]   = !rend;

        if (in_col_last) begin
            n_in_col = '0;
            n_in_row = (r_in_row == 2'd2) ? r_in_row : r_in_row + 2'd1;
        end else begin
            n_in_col = r_in_col + CW'(1);
            n_in_row = r_in_row;
        end
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (emit) begin
            if (fend) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (rend) begin
                n_out_col = '0;
                n_out_row = r_out_row + 16'd1;
            end else begin
                n_out_col = r_out_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (acc) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // Stage 1: line buffer read, with bypass of a write to the same column.
    gconv_pkg::t_pixel   r_px1;
    logic [CW-1:0]       r_addr1;
    logic [2:0]          r_rowok1, r_colok1;
    logic                r_rend1, r_fend1;
    logic                r_fwd_hit;
    logic [2*PXW-1:0]    r_fwd_data;
    logic [2*PXW-1:0]    rd_data;
    logic [2*PXW-1:0]    word1;
    logic [2*PXW-1:0]    wr_data;
    gconv_pkg::t_column  new_col;

    assign word1            = r_fwd_hit ? r_fwd_data : rd_data;
    assign new_col.row_top  = word1[PXW-1:0];
    assign new_col.row_mid  = word1[2*PXW-1:PXW];
    assign new_col.row_bot  = r_px1;
    assign wr_data          = {r_px1, new_col.row_mid};

    gconv_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (acc),
        .i_rd_addr (r_in_col),
        .o_rd_data (rd_data),
        .i_wr_en   (adv1),
        .i_wr_addr (r_addr1),
        .i_wr_data (wr_data),
        .o_busy    (line_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (acc) begin
            r_fwd_hit <= adv1 && (r_addr1 == r_in_col);
        end
        if (acc) begin
            r_fwd_data <= wr_data;
            r_px1      <= px;
            r_addr1    <= r_in_col;
            r_emit1    <= emit;
            r_rowok1   <= row_ok;
            r_colok1   <= col_ok;
            r_rend1    <= rend;
            r_fend1    <= fend;
        end
    end

    // Stage 2: window cells; stage 3: products held in the cells.
    logic [2:0] r_rowok2, r_colok2;
    logic       r_rend2, r_fend2;
    logic       r_rend3, r_fend3;

    gconv_pkg::t_column          cell_col  [TAPS];
    gconv_pkg::t_cell_ctl        cell_ctl  [TAPS];
    logic signed [COEF_BITS-1:0] cell_coef [TAPS][TAPS];
    logic signed [PW-1:0]        cell_prod [TAPS][TAPS];

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        gconv_pkg::t_column col_in;

        assign col_in = (k == TAPS - 1) ? new_col : cell_col[(k + 1) % TAPS];

        assign cell_ctl[k].shift   = adv1;
        assign cell_ctl[k].capture = mv23;
        assign cell_ctl[k].row_ok  = r_rowok2;
        assign cell_ctl[k].col_ok  = r_colok2[k];

        for (genvar r = 0; r < TAPS; r++) begin : g_row
            assign cell_coef[k][r] = coef[r][k];
        end

        gconv_cell #(
            .COEF_BITS (COEF_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (cell_ctl[k]),
            .i_column (col_in),
            .o_column (cell_col[k]),
            .i_coef   (cell_coef[k]),
            .o_prod   (cell_prod[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_emit2  <= r_emit1;
            r_rowok2 <= r_rowok1;
            r_colok2 <= r_colok1;
            r_rend2  <= r_rend1;
            r_fend2  <= r_fend1;
        end
        if (mv23) begin
            r_rend3 <= r_rend2;
            r_fend3 <= r_fend2;
        end
    end

    // Stage 4: sum of the products.
    logic signed [SW-1:0] n_sum;
    logic signed [SW-1:0] r_sum4;
    logic                 r_rend4, r_fend4;

    always_comb begin
        n_sum = '0;
        for (int c = 0; c < TAPS; c++) begin
            for (int r = 0; r < TAPS; r++) begin
                n_sum = n_sum + SW'(cell_prod[c][r]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_sum4  <= n_sum;
            r_rend4 <= r_rend3;
            r_fend4 <= r_fend3;
        end
    end

    // Output register: round to nearest and clamp.
    logic signed [SW-1:0] rnd;
    logic [7:0]           n_pix;
    logic [7:0]           r_pix;
    logic                 r_row_end, r_frame_end;

    always_comb begin
        rnd = r_sum4 + SW'(128);
        if (r_sum4 <= 0) begin
            n_pix = '0;
        end else if (rnd[SW-1:16] != '0) begin
            n_pix = 8'd255;
        end else begin
            n_pix = rnd[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r_pix       <= n_pix;
            r_row_end   <= r_rend4;
            r_frame_end <= r_fend4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_v1      <= acc  || (r_v1 && !adv1);
            r_v2      <= adv1 || (r_v2 && !adv2);
            r_v3      <= mv23 || (r_v3 && !adv3);
            r_v4      <= adv3 || (r_v4 && !adv4);
            r_o_valid <= adv4 || (r_o_valid && !i_ready);
        end
    end

    assign o_valid     = r_o_valid;
    assign o_pixel_out = r_pix;
    assign o_row_end   = r_row_end;
    assign o_frame_end = r_frame_end;

endmodule

// File: tb/tb_grayscale_conv2d_clamp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grayscale_conv2d_clamp
// Self-checking testbench of the streaming 3x3 grayscale convolution. Frames of
// random pixels go in under many kernels and frame sizes, with random gaps on
// both handshakes. Every output pixel and its row and frame flags are compared
// against a predictor that tracks the line buffers, the window and the counters.
// ----------------------------------------------------------------------------

class conv_pixel_board #(int KSIZE = 3, int MAX_W = 1024, int CBITS = 16);

    typedef struct packed {
        logic [7:0] pix;
        logic       row_end;
        logic       frame_end;
    } t_conv_pixel;

    localparam int unsigned ROW_SAT = 32'h10001;

    logic [47:0] coef_rows [3];
    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [7:0]  line_mem [2*MAX_W];
    logic [7:0]  win [9];
    int unsigned in_col;
    int unsigned in_row;
    int unsigned out_col;
    int unsigned out_row;
    t_conv_pixel pixels_due [$];
    int          errors;

    function new();
        coef_rows[0] = '0;
        coef_rows[1] = 48'h0000_0100_0000;
        coef_rows[2] = '0;
        width_reg    = 11'd1024;
        height_reg   = 16'd768;
        foreach (line_mem[k]) line_mem[k] = '0;
        foreach (win[k]) win[k] = '0;
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
        errors  = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [47:0] data);
        case (idx)
            gconv_pkg::CFG_COEF_TOP:     coef_rows[0] = data;
            gconv_pkg::CFG_COEF_MID:     coef_rows[1] = data;
            gconv_pkg::CFG_COEF_BOT:     coef_rows[2] = data;
            gconv_pkg::CFG_FRAME_WIDTH:  width_reg    = data[10:0];
            gconv_pkg::CFG_FRAME_HEIGHT: height_reg   = data[15:0];
            default: ;
        endcase
    endfunction

    function longint coef_at(int r, int c);
        logic [15:0] slot;
        longint      v;
        if (KSIZE <= 1) begin
            if (r != 1 || c != 1) return 0;
            slot = coef_rows[0][15:0];
        end else if (KSIZE == 2 && (r == 2 || c == 2)) begin
            return 0;
        end else begin
            slot = coef_rows[r][16*c +: 16];
        end
        v = longint'(slot) & ((longint'(1) << CBITS) - 1);
        if (v[CBITS-1]) v = v - (longint'(1) << CBITS);
        return v;
    endfunction

    function bit frame_start();
        return in_col == 0 && in_row == 0 && out_col == 0 && out_row == 0;
    endfunction

    function int pending();
        return pixels_due.size();
    endfunction

    // Advances the window by one accepted item and queues the pixel it completes.
    function void take_item(logic kind, logic [7:0] pix_in);
        int unsigned w;
        int unsigned h;
        logic [7:0]  px;
        logic [7:0]  up2;
        logic [7:0]  up1;
        bit          emit;
        longint      acc;
        longint      rr;
        longint      cc;
        t_conv_pixel res;
        w = width_reg;
        if (w == 0) w = 1;
        if (w > MAX_W) w = MAX_W;
        h = height_reg;
        if (h == 0) h = 1;
        px  = kind ? 8'd0 : pix_in;
        up2 = '0;
        up1 = '0;
        if (in_col < MAX_W) begin
            up2 = line_mem[in_col];
            up1 = line_mem[MAX_W + in_col];
            line_mem[in_col] = up1;
            line_mem[MAX_W + in_col] = px;
        end
        for (int r = 0; r < 3; r++) begin
            win[r*3]     = win[r*3 + 1];
            win[r*3 + 1] = win[r*3 + 2];
        end
        win[2] = up2;
        win[5] = up1;
        win[8] = px;
        emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        if (in_col + 1 >= w) begin
            in_col = 0;
            if (in_row < ROW_SAT) in_row++;
        end else begin
            in_col++;
        end
        if (!emit) return;
        acc = 0;
        for (int r = 0; r < 3; r++) begin
            rr = longint'(out_row) + r - 1;
            if (rr < 0 || rr >= longint'(h)) continue;
            for (int c = 0; c < 3; c++) begin
                cc = longint'(out_col) + c - 1;
                if (cc < 0 || cc >= longint'(w)) continue;
                acc += longint'(win[r*3 + c]) * coef_at(r, c);
            end
        end
        if (acc <= 0) begin
            res.pix = 8'd0;
        end else begin
            acc = (acc + 128) >>> 8;
            res.pix = (acc > 255) ? 8'hFF : acc[7:0];
        end
        res.row_end   = (out_col + 1 >= w);
        res.frame_end = res.row_end && (out_row + 1 >= h);
        pixels_due.push_back(res);
        if (res.frame_end) begin
            out_col = 0;
            out_row = 0;
            in_col  = 0;
            in_row  = 0;
        end else if (res.row_end) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
    endfunction

    function void check_pixel(logic [7:0] pix, logic row_end, logic frame_end);
        t_conv_pixel exp_px;
        if (pixels_due.size() == 0) begin
            $display("%0t: unexpected item: pixel_out %0d row_end %0b frame_end %0b",
                     $time, pix, row_end, frame_end);
            errors++;
            return;
        end
        exp_px = pixels_due.pop_front();
        if (pix !== exp_px.pix) begin
            $display("%0t: pixel_out expected %0d actual %0d", $time, exp_px.pix, pix);
            errors++;
        end
        if (row_end !== exp_px.row_end) begin
            $display("%0t: row_end expected %0b actual %0b", $time, exp_px.row_end, row_end);
            errors++;
        end
        if (frame_end !== exp_px.frame_end) begin
            $display("%0t: frame_end expected %0b actual %0b",
                     $time, exp_px.frame_end, frame_end);
            errors++;
        end
    endfunction

endclass

module tb_grayscale_conv2d_clamp;

    localparam int KSIZE          = 3;
    localparam int MAX_W          = 1024;
    localparam int CBITS          = 16;
    localparam int RANDOM_ITEMS   = 850;
    localparam int SETTLE_CYCLES  = 12;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam logic [gconv_pkg::CFG_IDX_W-1:0] CFG_IDX_LAST = '1;

    typedef enum int {COEF_MILD, COEF_ANY, COEF_EXTREME} t_coef_style;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_valid     = 1'b0;
    logic                            i_kind      = 1'b0;
    logic [7:0]                      i_pixel_in  = 8'd0;
    logic                            i_ready     = 1'b0;
    logic                            i_cfg_we    = 1'b0;
    logic [gconv_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [47:0]                     i_cfg_data  = '0;
    logic                            o_ready;
    logic                            o_valid;
    logic [7:0]                      o_pixel_out;
    logic                            o_row_end;
    logic                            o_frame_end;

    conv_pixel_board #(KSIZE, MAX_W, CBITS) sb;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_requests = 0;
    int          hold_seen     = 0;
    int          hold_left     = 0;
    int          quiet_cycles  = 0;
    logic [47:0] cur_top;
    logic [47:0] cur_mid;
    logic [47:0] cur_bot;
    logic [10:0] cur_wid;
    logic [15:0] cur_hgt;

    grayscale_conv2d_clamp #(
        .KERNEL_SIZE(KSIZE),
        .MAX_WIDTH  (MAX_W),
        .COEF_BITS  (CBITS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_kind     (i_kind),
        .i_pixel_in (i_pixel_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_pixel_out(o_pixel_out),
        .o_row_end  (o_row_end),
        .o_frame_end(o_frame_end),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_pixel(o_pixel_out, o_row_end, o_frame_end);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_grayscale_conv2d_clamp: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic kind, input logic [7:0] pix);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_kind     <= kind;
        i_pixel_in <= pix;
        do @(posedge i_clk); while (!o_ready);
        sb.take_item(kind, pix);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [gconv_pkg::CFG_IDX_W-1:0] idx,
                             input logic [47:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic program_regs();
        cfg_write(gconv_pkg::CFG_COEF_TOP, cur_top);
        cfg_write(gconv_pkg::CFG_COEF_MID, cur_mid);
        cfg_write(gconv_pkg::CFG_COEF_BOT, cur_bot);
        cfg_write(gconv_pkg::CFG_FRAME_WIDTH, 48'(cur_wid));
        cfg_write(gconv_pkg::CFG_FRAME_HEIGHT, 48'(cur_hgt));
        cfg_write(gconv_pkg::CFG_IDX_W'($urandom_range(gconv_pkg::CFG_FRAME_HEIGHT + 1,
                                                       CFG_IDX_LAST)),
                  48'({$urandom, $urandom}));
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [47:0] rand_coef_row(input t_coef_style style);
        logic [47:0] row;
        logic [15:0] picks [6];
        picks = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0100, 16'h0080};
        for (int s = 0; s < 3; s++) begin
            case (style)
                COEF_MILD: row[16*s +: 16] = 16'($urandom_range(0, 640)) - 16'd320;
                COEF_ANY:  row[16*s +: 16] = 16'($urandom);
                default:   row[16*s +: 16] = picks[$urandom_range(5)];
            endcase
        end
        return row;
    endfunction

    task automatic pick_kernel();
        t_coef_style style;
        style   = t_coef_style'($urandom_range(COEF_EXTREME));
        cur_top = rand_coef_row(style);
        cur_mid = rand_coef_row(style);
        cur_bot = rand_coef_row(style);
    endtask

    // Sends one frame in raster order followed by its flush items, or only
    // its first limit items when limit is positive and less than the frame's item count.
    task automatic send_frame(input int limit, inout int tally);
        int w_eff;
        int h_eff;
        int total;
        w_eff = (cur_wid == 0) ? 1 : (cur_wid > MAX_W) ? MAX_W : int'(cur_wid);
        h_eff = (cur_hgt == 0) ? 1 : int'(cur_hgt);
        total = w_eff * h_eff + w_eff + 1;
        if (limit > 0 && limit < total) total = limit;
        for (int k = 0; k < total; k++) begin
            if (k < w_eff * h_eff) send_item($urandom_range(15) == 0, 8'($urandom));
            else send_item(1'b1, 8'($urandom));
            tally++;
        end
    endtask

    initial begin
        int random_items;
        int other_items;
        int frames;
        random_items = 0;
        other_items  = 0;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 23;
        recv_idle_pct = 67;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);

        cur_top = 48'h7FFF_8000_FFFF;
        cur_mid = 48'h0080_0100_0080;
        cur_bot = 48'h0001_FF00_0000;
        cur_wid = 11'd3;
        cur_hgt = 16'd3;
        program_regs();
        send_item(1'b0, 8'd0);
        send_item(1'b0, 8'd255);
        send_item(1'b0, 8'd1);
        send_item(1'b0, 8'd128);
        send_item(1'b0, 8'd255);
        send_item(1'b0, 8'd0);
        send_item(1'b0, 8'd254);
        send_item(1'b0, 8'd127);
        send_item(1'b0, 8'd255);
        send_item(1'b1, 8'hFF);
        send_item(1'b1, 8'h00);
        send_item(1'b1, 8'hAA);
        send_item(1'b1, 8'h55);
        wait_idle();

        // Zero width and height act as one; a half coefficient gives rounding ties.
        cur_top = '0;
        cur_mid = 48'h0000_0080_0000;
        cur_bot = '0;
        cur_wid = 11'd0;
        cur_hgt = 16'd0;
        program_regs();
        send_item(1'b0, 8'd1);
        send_item(1'b1, 8'hFF);
        send_item(1'b1, 8'h80);
        send_item(1'b0, 8'd3);
        send_item(1'b1, 8'h01);
        send_item(1'b1, 8'h7F);
        wait_idle();

        // A flush item in the middle of the frame counts as a zero pixel.
        cur_top = 48'h0040_0040_0040;
        cur_mid = 48'h0040_0100_0040;
        cur_bot = 48'h0040_0040_0040;
        cur_wid = 11'd2;
        cur_hgt = 16'd2;
        program_regs();
        send_item(1'b0, 8'd200);
        send_item(1'b1, 8'hFF);
        send_item(1'b0, 8'd7);
        send_item(1'b0, 8'd9);
        send_item(1'b1, 8'h33);
        send_item(1'b1, 8'hCC);
        send_item(1'b1, 8'hF0);
        wait_idle();

        // A longer frame while the output is held off for a long stretch.
        pick_kernel();
        cur_wid = 11'd24;
        cur_hgt = 16'd4;
        program_regs();
        hold_requests <= hold_requests + 1;
        send_frame(0, other_items);
        wait_idle();

        while (random_items < RANDOM_ITEMS) begin
            if (random_items < RANDOM_ITEMS / 3) begin
                send_idle_pct = 23;
                recv_idle_pct = 67;
            end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 67;
                recv_idle_pct = 23;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick_kernel();
            cur_wid = 11'($urandom_range(0, 12));
            cur_hgt = 16'($urandom_range(0, 5));
            program_regs();
            frames = $urandom_range(1, 3);
            repeat (frames) send_frame(0, random_items);
            if ($urandom_range(4) == 0) begin
                // Stop inside a frame, change its geometry and run it to its end.
                send_frame($urandom_range(1, 40), random_items);
                wait_idle();
                cur_wid = 11'($urandom_range(0, 12));
                cur_hgt = 16'($urandom_range(0, 5));
                program_regs();
                while (!sb.frame_start()) begin
                    send_item(1'($urandom_range(1)), 8'($urandom));
                    random_items++;
                end
            end
            wait_idle();
        end

        if (sb.errors == 0) begin
            $display("tb_grayscale_conv2d_clamp: PASS");
        end else begin
            $display("tb_grayscale_conv2d_clamp: FAIL");
        end
        $finish;
    end

endmodule
